// File: sv/fpca_pkg.sv
// Package of the flash page chunk assembler: sizes, result kinds, register indexes and beat types.
package fpca_pkg;

   // Geometry of the page buffers and the flash.
   localparam int PAGE_BYTES      = 256;
   localparam int BUFFER_COUNT    = 2;
   localparam int SECTOR_BYTES    = 4096;
   localparam int CHUNKS_PER_PAGE = PAGE_BYTES / 8;
   localparam int STORE_WORDS     = BUFFER_COUNT * CHUNKS_PER_PAGE;

   localparam int ADDR_W   = 24;
   localparam int DATA_W   = 64;
   localparam int COUNT_W  = 16;
   localparam int IDX_W    = $clog2(CHUNKS_PER_PAGE);
   localparam int PAGE_SH  = $clog2(PAGE_BYTES);
   localparam int SECT_SH  = $clog2(SECTOR_BYTES);
   localparam int FILL_W   = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
   localparam int STORE_AW = $clog2(STORE_WORDS);

   localparam logic [ADDR_W-1:0] REGION_OFFSET = 24'h040000;

   // Configuration port.
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   typedef enum logic [1:0] {
      REG_TOTAL_PAGES   = 2'd0,
      REG_REGION_SELECT = 2'd1,
      REG_ARMED         = 2'd2,
      REG_UNUSED        = 2'd3
   } reg_index_type;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_DROPPED  = 2'd0,
      KIND_ACCEPTED = 2'd1,
      KIND_ERASE    = 2'd2,
      KIND_PROGRAM  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [ADDR_W-1:0] chunk_addr;
      logic [DATA_W-1:0] chunk_data;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      logic [ADDR_W-1:0]  flash_addr;
      logic [DATA_W-1:0]  data_word;
      logic [COUNT_W-1:0] pages_done;
      logic               all_received;
      logic               last;
   } rsp_type;

endpackage

// File: sv/flash_page_chunk_assembler_top.sv
// Flash page chunk assembler: places firmware chunks in page buffers and emits erase and program beats.
//
// Usage
//  - Input: a chunk beat (address, eight data bytes) is taken on req_payload at a rising
//    edge where start is high and busy is low.
//  - Results: each result beat is shown on rsp_payload for exactly one cycle with
//    rsp_valid high; the receiver cannot stall, so it must take every beat as shown.
//  - Configuration: APB-style port, total_pages at 0x0, region_select at 0x4, armed at 0x8;
//    pready is always high. Write registers only while busy is low.
//  - Single results: a dropped or merely stored chunk gives one result beat in the cycle after
//    it is taken; busy stays high while that beat is shown, so no new chunk is taken until then.
//  - A chunk that completes a page gives an optional sector erase beat and then 32 program
//    beats, one a cycle, read one word a cycle out of the page store (one read port, a
//    registered read). Such a chunk keeps busy high until the last program beat is shown.
//  - Reset (synchronous, active high) clears the registers, chunk maps, page count and the
//    fill buffer choice. The page store is not cleared: a page is only read out once all
//    its chunks have been written into that buffer.
module flash_page_chunk_assembler_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  fpca_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   output fpca_pkg::rsp_type                    rsp_payload,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [fpca_pkg::CSR_AW-1:0]          paddr,
   input  logic [fpca_pkg::CSR_DW-1:0]          pwdata,
   output logic [fpca_pkg::CSR_DW-1:0]          prdata,
   output logic                                 pready
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ERASE = 3'b010,
      ST_READ  = 3'b100
   } state_type;

   localparam logic [fpca_pkg::CHUNKS_PER_PAGE-1:0] FULL_MAP = '1;
   localparam logic [fpca_pkg::IDX_W-1:0]           LAST_IDX =
      fpca_pkg::IDX_W'(fpca_pkg::CHUNKS_PER_PAGE - 1);
   localparam logic [fpca_pkg::FILL_W-1:0]          LAST_BUF =
      fpca_pkg::FILL_W'(fpca_pkg::BUFFER_COUNT - 1);

   // Configuration registers.
   logic [fpca_pkg::COUNT_W-1:0] total_pages_ff;
   logic                         region_select_ff;
   logic                         armed_ff;

   // Block state.
   logic [fpca_pkg::CHUNKS_PER_PAGE-1:0] chunk_map_ff   [fpca_pkg::BUFFER_COUNT];
   logic [fpca_pkg::ADDR_W-1:0]          buffer_addr_ff [fpca_pkg::BUFFER_COUNT];
   logic [fpca_pkg::ADDR_W-1:0]          previous_addr_ff;
   logic [fpca_pkg::FILL_W-1:0]          fill_select_ff;
   logic [fpca_pkg::COUNT_W-1:0]         page_count_ff;
   logic [fpca_pkg::DATA_W-1:0]          page_store [fpca_pkg::STORE_WORDS];

   // Sequencer.
   state_type                    state_ff, state_in;
   logic [fpca_pkg::IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [fpca_pkg::FILL_W-1:0]  rd_buf_ff;
   logic [fpca_pkg::ADDR_W-1:0]  flash_base_ff;
   logic                         pg_valid_ff;
   logic [fpca_pkg::IDX_W-1:0]   pg_idx_ff;
   logic [fpca_pkg::DATA_W-1:0]  mem_q_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   fpca_pkg::rsp_type            rsp_ff, rsp_in;

   // Decode of the incoming chunk.
   logic                         accept;
   logic                         csr_write;
   fpca_pkg::reg_index_type      csr_index;
   logic [fpca_pkg::ADDR_W-1:0]  chunk_addr;
   logic [fpca_pkg::IDX_W-1:0]   chunk_idx;
   logic                         drop;
   logic                         same_page;
   logic [fpca_pkg::CHUNKS_PER_PAGE-1:0] map_in;
   logic                         complete;
   logic [fpca_pkg::ADDR_W-1:0]  flash_base_in;
   logic [fpca_pkg::FILL_W-1:0]  fill_next;
   logic [fpca_pkg::COUNT_W-1:0] page_count_in;
   logic                         all_received;

   assign accept     = start && !busy;
   assign csr_write  = psel && penable && pwrite && pready;
   assign csr_index  = fpca_pkg::reg_index_type'(paddr[3:2]);
   assign chunk_addr = {req_payload.chunk_addr[fpca_pkg::ADDR_W-1:3], 3'b000};
   assign chunk_idx  = chunk_addr[fpca_pkg::PAGE_SH-1:3];

   assign drop = !armed_ff || (total_pages_ff == '0) || (page_count_ff >= total_pages_ff) ||
                 (chunk_addr == previous_addr_ff);

   // A chunk of another page than the one last seen in the fill buffer restarts its map.
   assign same_page = buffer_addr_ff[fill_select_ff][fpca_pkg::ADDR_W-1:fpca_pkg::PAGE_SH] ==
                      chunk_addr[fpca_pkg::ADDR_W-1:fpca_pkg::PAGE_SH];
   assign map_in    = (same_page ? chunk_map_ff[fill_select_ff] : '0) |
                      (fpca_pkg::CHUNKS_PER_PAGE'(1) << chunk_idx);
   assign complete  = (chunk_idx == LAST_IDX) && (map_in == FULL_MAP);

   assign flash_base_in = {chunk_addr[fpca_pkg::ADDR_W-1:fpca_pkg::PAGE_SH],
                           {fpca_pkg::PAGE_SH{1'b0}}} +
                          (region_select_ff ? fpca_pkg::REGION_OFFSET : '0);
   assign fill_next     = (fill_select_ff == LAST_BUF) ? '0 : fill_select_ff + 1'b1;
   assign page_count_in = page_count_ff + 1'b1;
   assign all_received  = page_count_ff >= total_pages_ff;

   assign busy = (state_ff != ST_IDLE) || pg_valid_ff || rsp_valid_ff;

   // Configuration port.
   assign pready = 1'b1;

   always_comb begin
      case (csr_index)
         fpca_pkg::REG_TOTAL_PAGES:   prdata = fpca_pkg::CSR_DW'(total_pages_ff);
         fpca_pkg::REG_REGION_SELECT: prdata = fpca_pkg::CSR_DW'(region_select_ff);
         fpca_pkg::REG_ARMED:         prdata = fpca_pkg::CSR_DW'(armed_ff);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_pages_ff   <= '0;
         region_select_ff <= 1'b0;
         armed_ff         <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            fpca_pkg::REG_TOTAL_PAGES:   total_pages_ff   <= pwdata[fpca_pkg::COUNT_W-1:0];
            fpca_pkg::REG_REGION_SELECT: region_select_ff <= pwdata[0];
            fpca_pkg::REG_ARMED:         armed_ff         <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Chunk bookkeeping: maps, buffer addresses, page count and fill buffer.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < fpca_pkg::BUFFER_COUNT; b++) begin
            chunk_map_ff[b]   <= '0;
            buffer_addr_ff[b] <= (b == 0) ? '1 : '0;
         end
         previous_addr_ff <= '1;
         fill_select_ff   <= '0;
         page_count_ff    <= '0;
      end else if (accept && !drop) begin
         previous_addr_ff <= chunk_addr;
         if (complete) begin
            chunk_map_ff[fill_select_ff] <= '0;
            page_count_ff                <= page_count_in;
            fill_select_ff               <= fill_next;
            buffer_addr_ff[fill_next]    <= '1;
            if (fill_next != fill_select_ff) begin
               buffer_addr_ff[fill_select_ff] <= chunk_addr;
            end
         end else begin
            chunk_map_ff[fill_select_ff]   <= map_in;
            buffer_addr_ff[fill_select_ff] <= chunk_addr;
         end
      end
   end

   // Page store: written by each stored chunk, read one word a cycle during readout.
   always_ff @(posedge clock) begin
      if (accept && !drop) begin
         page_store[{fill_select_ff, chunk_idx}] <= req_payload.chunk_data;
      end
      mem_q_ff <= page_store[{rd_buf_ff, rd_idx_ff}];
   end

   // Sequencer next state and the single-beat results.
   always_comb begin
      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in.flash_addr   = '0;
               rsp_in.data_word    = '0;
               rsp_in.pages_done   = page_count_ff;
               rsp_in.all_received = all_received;
               rsp_in.last         = 1'b1;
               rd_idx_in           = '0;
               if (drop) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.kind  = fpca_pkg::KIND_DROPPED;
               end else if (!complete) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.kind  = fpca_pkg::KIND_ACCEPTED;
               end else if (flash_base_in[fpca_pkg::SECT_SH-1:0] == '0) begin
                  state_in = ST_ERASE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_ERASE: begin
            rsp_valid_in        = 1'b1;
            rsp_in.kind         = fpca_pkg::KIND_ERASE;
            rsp_in.flash_addr   = flash_base_ff >> fpca_pkg::SECT_SH;
            rsp_in.data_word    = '0;
            rsp_in.pages_done   = page_count_ff;
            rsp_in.all_received = all_received;
            rsp_in.last         = 1'b0;
            state_in            = ST_READ;
         end
         ST_READ: begin
            rd_idx_in = rd_idx_ff + 1'b1;
            if (rd_idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pg_valid_ff  <= 1'b0;
         rd_idx_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pg_valid_ff  <= (state_ff == ST_READ);
         rd_idx_ff    <= rd_idx_in;
      end
   end

   // Payload registers of the readout.
   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      pg_idx_ff <= rd_idx_ff;
      if (state_ff == ST_IDLE && accept) begin
         rd_buf_ff     <= fill_select_ff;
         flash_base_ff <= flash_base_in;
      end
   end

   // Result beat: a program word from the store, otherwise the single-beat result.
   always_comb begin
      if (pg_valid_ff) begin
         rsp_valid                = 1'b1;
         rsp_payload.kind         = fpca_pkg::KIND_PROGRAM;
         rsp_payload.flash_addr   = flash_base_ff +
                                    fpca_pkg::ADDR_W'({pg_idx_ff, 3'b000});
         rsp_payload.data_word    = mem_q_ff;
         rsp_payload.pages_done   = page_count_ff;
         rsp_payload.all_received = all_received;
         rsp_payload.last         = (pg_idx_ff == LAST_IDX);
      end else begin
         rsp_valid   = rsp_valid_ff;
         rsp_payload = rsp_ff;
      end
   end

endmodule
